>>> src/button_press_classifier_top_assert.svh
// Assertion macros shared by the button press classifier RTL.
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// Check on the rising clock edge, skipped while reset is asserted.
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on the rising clock edge, reset cycles included.
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/bpc_pkg.sv
// Types, constants and codes of the button press classifier.
`default_nettype none
package bpc_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CmpW       = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam int unsigned LimitW  = 16;
  localparam int unsigned CfgAddrW = 8;

  localparam logic [7:0] STATUS_NONE  = 8'h00;
  localparam logic [7:0] STATUS_LONG  = 8'h0A;
  localparam logic [7:0] STATUS_SHORT = 8'h0B;

  localparam logic [LimitW-1:0] HOLD_RESET     = LimitW'(2000);
  localparam logic [LimitW-1:0] DEBOUNCE_RESET = LimitW'(2);
  localparam logic [LimitW-1:0] SHORT_RESET    = LimitW'(2000);
  localparam logic [LimitW-1:0] ROLLOVER_RESET = LimitW'(30000);

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CHECK   = 3'd1,
    OP_PRESS   = 3'd2,
    OP_RELEASE = 3'd3,
    OP_HOST    = 3'd4
  } opcode_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_HOLD        = 8'd0,
    REG_DEBOUNCE    = 8'd1,
    REG_SHORT_CLEAR = 8'd2,
    REG_ROLLOVER    = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [LimitW-1:0] hold_limit_ms;
    logic [LimitW-1:0] debounce_limit_ms;
    logic [LimitW-1:0] short_clear_ms;
    logic [LimitW-1:0] rollover_ms;
  } cfg_t;

  typedef struct packed {
    logic       status_changed;
    logic       button_down;
    logic [15:0] elapsed_ms;
    logic [7:0]  status_value;
  } res_t;

endpackage
`default_nettype wire

>>> src/bpc_core.sv
// Press state, elapsed counter and per-event update of the classifier.
`default_nettype none
module bpc_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [2:0]    opcode_i,
  input  wire logic [7:0]    host_value_i,
  input  bpc_pkg::cfg_t      cfg_i,
  output bpc_pkg::res_t      res_o
);
  import bpc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  run_q, run_d;
  logic                  held_q, held_d;
  logic                  long_q, long_d;
  logic [7:0]            stat_q, stat_d;
  logic                  chg;
  logic [CmpW-1:0]       d_ext;
  logic [CmpW-1:0]       hold_ext, deb_ext, clr_ext, roll_ext;

  assign d_ext    = CmpW'(cnt_q);
  assign hold_ext = CmpW'(cfg_i.hold_limit_ms);
  assign deb_ext  = CmpW'(cfg_i.debounce_limit_ms);
  assign clr_ext  = CmpW'(cfg_i.short_clear_ms);
  assign roll_ext = CmpW'(cfg_i.rollover_ms);

  always_comb begin
    cnt_d  = cnt_q;
    run_d  = run_q;
    held_d = held_q;
    long_d = long_q;
    stat_d = stat_q;
    chg    = 1'b0;
    if (step_i) begin
      unique case (opcode_i)
        OP_TICK: begin
          if (run_q && (cnt_q != CountMax)) cnt_d = cnt_q + COUNT_BITS'(1);
        end
        OP_CHECK: begin
          if ((d_ext >= hold_ext) && held_q && !long_q) begin
            stat_d = STATUS_LONG;
            long_d = 1'b1;
            chg    = 1'b1;
          end else if ((d_ext >= clr_ext) && (stat_q == STATUS_SHORT)) begin
            cnt_d  = '0;
            stat_d = STATUS_NONE;
            long_d = 1'b0;
            chg    = 1'b1;
          end
          // rollover looks at the count before this event
          if (d_ext >= roll_ext) cnt_d = '0;
        end
        OP_PRESS: begin
          cnt_d  = '0;
          run_d  = 1'b1;
          held_d = 1'b1;
        end
        OP_RELEASE: begin
          held_d = 1'b0;
          if ((stat_q == STATUS_LONG) || long_q) begin
            stat_d = STATUS_NONE;
            long_d = 1'b0;
            cnt_d  = '0;
            chg    = 1'b1;
          end else if ((d_ext < hold_ext) && (d_ext > deb_ext)) begin
            stat_d = STATUS_SHORT;
            long_d = 1'b0;
            chg    = 1'b1;
          end
        end
        OP_HOST: begin
          stat_d = host_value_i;
          chg    = 1'b1;
        end
        default: begin
          // unused codes leave the state alone
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      held_q <= 1'b0;
      long_q <= 1'b0;
      stat_q <= STATUS_NONE;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      held_q <= held_d;
      long_q <= long_d;
      stat_q <= stat_d;
    end
  end

  logic [CmpW-1:0] cnt_d_ext;
  assign cnt_d_ext = CmpW'(cnt_d);

  assign res_o.status_value   = stat_d;
  assign res_o.elapsed_ms     = cnt_d_ext[15:0];
  assign res_o.button_down    = held_d;
  assign res_o.status_changed = chg;

`include "button_press_classifier_top_assert.svh"

  `BPC_ASSERT(a_long_needs_held, long_q |-> held_q, "long flag set without a held button")
  `BPC_ASSERT_ALWAYS(a_stopped_count_zero, !run_q |-> (cnt_q == '0),
                     "counter moved while stopped")
  `BPC_ASSERT(a_idle_holds_state, !step_i |=> ($stable(cnt_q) && $stable(stat_q)),
              "state changed without an event")

endmodule
`default_nettype wire

>>> src/button_press_classifier_top.sv
// Top level of the button press classifier: stream ports, config registers, result register.
//
//  channel  | direction | handshake                        | contents
//  s_axis   | in        | s_axis_tvalid_i / s_axis_tready_o | event word: opcode, host_value
//  m_axis   | out       | m_axis_tvalid_o / m_axis_tready_i | result word: status, elapsed, flags
//  cfg      | in        | cfg_valid_i / cfg_ready_o         | register index and 16-bit value
//
// The state update and the result register load happen on the accepting edge, so one
// word per clock is sustained while no result waits with m_axis_tready_i low.
// The result register frees up in the same cycle it is taken, so input stalls only
// while a result waits with m_axis_tready_i low.
// Reset (rst_ni low, asynchronous) clears state, limits to defaults, output empty.
`default_nettype none
module button_press_classifier_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [2:0] opcode, [10:3] host_value, rest zero
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o,   // [7:0] status_value, [23:8] elapsed_ms,
                                             // [24] button_down, [25] status_changed
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [bpc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [bpc_pkg::LimitW-1:0]   cfg_data_i
);
  import bpc_pkg::*;

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_vld_q;
  logic in_acc;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_limit_ms     <= HOLD_RESET;
      cfg_q.debounce_limit_ms <= DEBOUNCE_RESET;
      cfg_q.short_clear_ms    <= SHORT_RESET;
      cfg_q.rollover_ms       <= ROLLOVER_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_HOLD:        cfg_q.hold_limit_ms     <= cfg_data_i;
        REG_DEBOUNCE:    cfg_q.debounce_limit_ms <= cfg_data_i;
        REG_SHORT_CLEAR: cfg_q.short_clear_ms    <= cfg_data_i;
        REG_ROLLOVER:    cfg_q.rollover_ms       <= cfg_data_i;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  bpc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_acc),
    .opcode_i     (s_axis_tdata_i[2:0]),
    .host_value_i (s_axis_tdata_i[10:3]),
    .cfg_i        (cfg_q),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_acc) res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, res_q};

`include "button_press_classifier_top_assert.svh"

  `BPC_ASSERT(a_accept_gives_word, in_acc |=> m_axis_tvalid_o,
              "accepted event produced no result word")
  `BPC_ASSERT(a_no_accept_when_full, (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o,
              "input taken while result word still waits")
  `BPC_ASSERT(a_result_matches_load, in_acc |=> (m_axis_tdata_o[25:0] == $past(res_d)),
              "result register does not hold the updated state")

endmodule
`default_nettype wire

>>> dv/tb_button_press_classifier_top.sv
// Self-checking testbench for the button press classifier top level.
`default_nettype none
module tb_button_press_classifier_top;
  import bpc_pkg::*;

  // Opcode values the block must ignore.
  localparam logic [2:0] OP_IGN_LO  = 3'd5;
  localparam logic [2:0] OP_IGN_MID = 3'd6;
  localparam logic [2:0] OP_IGN_HI  = 3'd7;

  localparam logic [CfgAddrW-1:0] REG_UNUSED = 8'hFF;

  localparam int LIMIT_CYCLES    = 600000;
  localparam int PRESSURE_CYCLES = 60;
  localparam int MIX_ITEMS       = 145;
  localparam int NUM_PHASES      = 6;
  localparam int PRESSURE_PHASE  = 2;
  localparam int MAX_REPORTS     = 20;

  localparam cfg_t PHASE_CFG [NUM_PHASES] = '{
    '{16'd8,     16'd2,     16'd6,     16'd20},
    '{16'd1,     16'd0,     16'd1,     16'd1},
    '{16'd12,    16'd3,     16'd10,    16'd30},
    '{16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd5,     16'd1,     16'd4,     16'd9},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF}
  };
  localparam int PHASE_SRC_IDLE [NUM_PHASES] = '{0, 78, 0, 26, 0, 0};
  localparam int PHASE_RX_STALL [NUM_PHASES] = '{0, 0, 78, 26, 0, 0};

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] hv;
    logic       typed;
    res_t       want;
  } dir_row_t;

  // want is {status_changed, button_down, elapsed_ms, status_value}
  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{OP_TICK,    8'h00, 1'b1, '{1'b0, 1'b0, 16'd0, STATUS_NONE}},
    '{OP_CHECK,   8'h5A, 1'b1, '{1'b0, 1'b0, 16'd0, STATUS_NONE}},
    '{OP_RELEASE, 8'hA5, 1'b1, '{1'b0, 1'b0, 16'd0, STATUS_NONE}},
    '{OP_HOST,    8'hFF, 1'b1, '{1'b1, 1'b0, 16'd0, 8'hFF}},
    '{OP_IGN_LO,  8'h00, 1'b1, '{1'b0, 1'b0, 16'd0, 8'hFF}},
    '{OP_IGN_MID, 8'hFF, 1'b1, '{1'b0, 1'b0, 16'd0, 8'hFF}},
    '{OP_IGN_HI,  8'h55, 1'b1, '{1'b0, 1'b0, 16'd0, 8'hFF}},
    '{OP_HOST,    8'h00, 1'b1, '{1'b1, 1'b0, 16'd0, STATUS_NONE}},
    '{OP_PRESS,   8'hAA, 1'b1, '{1'b0, 1'b1, 16'd0, STATUS_NONE}},
    '{OP_TICK,    8'h33, 1'b0, '0},
    '{OP_TICK,    8'hCC, 1'b0, '0},
    '{OP_TICK,    8'h0F, 1'b0, '0},
    '{OP_RELEASE, 8'hF0, 1'b0, '0},
    '{OP_CHECK,   8'h00, 1'b0, '0},
    '{OP_PRESS,   8'hFF, 1'b0, '0},
    '{OP_TICK,    8'h81, 1'b0, '0},
    '{OP_RELEASE, 8'h7E, 1'b0, '0},
    '{OP_HOST,    STATUS_LONG, 1'b0, '0},
    '{OP_RELEASE, 8'h00, 1'b1, '{1'b1, 1'b0, 16'd0, STATUS_NONE}},
    '{OP_RELEASE, 8'hFF, 1'b1, '{1'b0, 1'b0, 16'd0, STATUS_NONE}},
    '{OP_HOST,    STATUS_SHORT, 1'b0, '0},
    '{OP_CHECK,   8'h96, 1'b0, '0},
    '{OP_TICK,    8'h69, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                tx_valid = 1'b0;
  logic [15:0]         tx_data  = '0;
  logic                tx_typed = 1'b0;
  res_t                tx_want  = '0;
  logic                rx_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [LimitW-1:0]   cfg_data  = '0;

  wire logic        s_axis_tready_o;
  wire logic        m_axis_tvalid_o;
  wire logic [31:0] m_axis_tdata_o;
  wire logic        cfg_ready_o;

  // Predictor state and limits
  cfg_t                  lim_q    = '{HOLD_RESET, DEBOUNCE_RESET, SHORT_RESET, ROLLOVER_RESET};
  logic [COUNT_BITS-1:0] cnt_q    = '0;
  logic                  run_q    = 1'b0;
  logic                  held_q   = 1'b0;
  logic                  long_q   = 1'b0;
  logic [7:0]            status_q = STATUS_NONE;

  res_t pending_results [$];

  int err_cnt      = 0;
  int results_cnt  = 0;
  int sent_cnt     = 0;
  int cfg_writes   = 0;
  int cycle_cnt    = 0;
  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int src_calm     = 0;
  int rx_calm      = 0;
  int hold_reqs    = 0;
  int hold_served  = 0;
  int hold_left    = 0;

  button_press_classifier_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (tx_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (tx_data),      // [2:0] opcode, [10:3] host_value
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (rx_ready),
    .m_axis_tdata_o  (m_axis_tdata_o), // [7:0] status, [23:8] elapsed, [24] down, [25] changed
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Classify one event against the predictor state and return the result word.
  function automatic res_t classify_event(input logic [2:0] op, input logic [7:0] hv);
    res_t                  r;
    logic [COUNT_BITS-1:0] seen;
    logic                  wrote;
    seen  = cnt_q;
    wrote = 1'b0;
    case (op)
      OP_TICK: begin
        if (run_q && cnt_q != '1) cnt_q = cnt_q + 1'b1;
      end
      OP_CHECK: begin
        if (seen >= lim_q.hold_limit_ms && held_q && !long_q) begin
          status_q = STATUS_LONG;
          long_q   = 1'b1;
          wrote    = 1'b1;
        end else if (seen >= lim_q.short_clear_ms && status_q == STATUS_SHORT) begin
          cnt_q    = '0;
          status_q = STATUS_NONE;
          long_q   = 1'b0;
          wrote    = 1'b1;
        end
        // rollover looks at the count from before this check
        if (seen >= lim_q.rollover_ms) cnt_q = '0;
      end
      OP_PRESS: begin
        cnt_q  = '0;
        run_q  = 1'b1;
        held_q = 1'b1;
      end
      OP_RELEASE: begin
        held_q = 1'b0;
        if (status_q == STATUS_LONG || long_q) begin
          status_q = STATUS_NONE;
          long_q   = 1'b0;
          cnt_q    = '0;
          wrote    = 1'b1;
        end else if (seen < lim_q.hold_limit_ms && seen > lim_q.debounce_limit_ms) begin
          status_q = STATUS_SHORT;
          long_q   = 1'b0;
          wrote    = 1'b1;
        end
      end
      OP_HOST: begin
        status_q = hv;
        wrote    = 1'b1;
      end
      default: ;
    endcase
    r.status_value   = status_q;
    r.elapsed_ms     = 16'(cnt_q);
    r.button_down    = held_q;
    r.status_changed = wrote;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("mismatch on %s: got 0x%0h, want 0x%0h (result %0d)",
               what, got, want, results_cnt);
  endtask

  // Monitor: retire results first, then predict for the word taken on this edge.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_n) begin
      if (m_axis_tvalid_o && rx_ready) begin
        results_cnt++;
        got = m_axis_tdata_o[25:0];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata_o, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.status_value !== want.status_value)
            report_mismatch("status_value", got.status_value, want.status_value);
          if (got.elapsed_ms !== want.elapsed_ms)
            report_mismatch("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
          if (got.button_down !== want.button_down)
            report_mismatch("button_down", got.button_down, want.button_down);
          if (got.status_changed !== want.status_changed)
            report_mismatch("status_changed", got.status_changed, want.status_changed);
          if (m_axis_tdata_o[31:26] !== '0)
            report_mismatch("padding", m_axis_tdata_o[31:26], 0);
        end
      end
      if (tx_valid && s_axis_tready_o) begin
        want = classify_event(tx_data[2:0], tx_data[10:3]);
        pending_results.push_back(tx_typed ? tx_want : want);
      end
    end
  end

  // Receiver: long hold-off on request, calm stretches, otherwise random stalls.
  always @(negedge clk_i) begin
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left   <= PRESSURE_CYCLES;
      rx_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_ready  <= 1'b0;
    end else if (rx_calm != 0) begin
      rx_calm  <= rx_calm - 1;
      rx_ready <= 1'b1;
    end else if ($urandom_range(63) == 0) begin
      rx_calm  <= 24;
      rx_ready <= 1'b1;
    end else begin
      rx_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("tb_button_press_classifier_top NOT OK");
      $finish;
    end
  end

  task automatic send_event(input logic [2:0] op, input logic [7:0] hv,
                            input logic typed, input res_t want);
    @(negedge clk_i);
    if (src_calm != 0) begin
      src_calm--;
    end else if ($urandom_range(39) == 0) begin
      src_calm = 20;
    end else begin
      while ($urandom_range(99) < src_idle_pct) begin
        tx_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    tx_valid <= 1'b1;
    tx_data  <= {5'b0, hv, op};
    tx_typed <= typed;
    tx_want  <= want;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_cnt++;
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [LimitW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
    case (idx)
      REG_HOLD:        lim_q.hold_limit_ms     = val;
      REG_DEBOUNCE:    lim_q.debounce_limit_ms = val;
      REG_SHORT_CLEAR: lim_q.short_clear_ms    = val;
      REG_ROLLOVER:    lim_q.rollover_ms       = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, let every expected word drain, then let the clock run on idle.
  task automatic wait_drained();
    @(negedge clk_i);
    tx_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly press/hold/release runs with random length, plus host writes and noise.
  task automatic run_mix(input int n);
    int stop_at;
    int cap_h;
    int cap_s;
    int len;
    int pick;
    logic [7:0] byte_v;
    stop_at = sent_cnt + n;
    cap_h = (lim_q.hold_limit_ms > 30) ? 30 : int'(lim_q.hold_limit_ms);
    cap_s = (lim_q.short_clear_ms > 30) ? 30 : int'(lim_q.short_clear_ms);
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_event(OP_PRESS, 8'($urandom), 1'b0, '0);
        len = $urandom_range(2 * cap_h + 3);
        repeat (len)
          send_event(($urandom_range(3) == 0) ? OP_CHECK : OP_TICK, 8'($urandom), 1'b0, '0);
        send_event(OP_RELEASE, 8'($urandom), 1'b0, '0);
        len = $urandom_range(2 * cap_s + 3);
        repeat (len)
          send_event(($urandom_range(2) == 0) ? OP_CHECK : OP_TICK, 8'($urandom), 1'b0, '0);
      end else if (pick < 80) begin
        case ($urandom_range(2))
          0:       byte_v = STATUS_LONG;
          1:       byte_v = STATUS_SHORT;
          default: byte_v = 8'($urandom);
        endcase
        send_event(OP_HOST, byte_v, 1'b0, '0);
      end else if (pick < 92) begin
        send_event(3'($urandom_range(int'(OP_HOST))), 8'($urandom), 1'b0, '0);
      end else begin
        send_event(3'($urandom_range(int'(OP_IGN_HI), int'(OP_IGN_LO))), 8'($urandom),
                   1'b0, '0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // an index past the register list must change nothing
    write_reg(REG_UNUSED, 16'hFFFF);
    for (int k = 0; k < DIR_ROWS; k++)
      send_event(DIR_TAB[k].op, DIR_TAB[k].hv, DIR_TAB[k].typed, DIR_TAB[k].want);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_HOLD,        PHASE_CFG[p].hold_limit_ms);
      write_reg(REG_DEBOUNCE,    PHASE_CFG[p].debounce_limit_ms);
      write_reg(REG_SHORT_CLEAR, PHASE_CFG[p].short_clear_ms);
      write_reg(REG_ROLLOVER,    PHASE_CFG[p].rollover_ms);
      src_idle_pct = PHASE_SRC_IDLE[p];
      rx_stall_pct = PHASE_RX_STALL[p];
      if (p == PRESSURE_PHASE) hold_reqs++;
      run_mix(MIX_ITEMS);
      wait_drained();
    end

    src_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (8) @(posedge clk_i);

    $display("covered %0d events, %0d results checked", sent_cnt, results_cnt);
    $display("%0d register writes over %0d limit settings, with input and output stalls",
             cfg_writes, NUM_PHASES + 1);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_button_press_classifier_top OK");
    end else begin
      $display("tb_button_press_classifier_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> button_press_classifier_top.f
+incdir+src
src/bpc_pkg.sv
src/bpc_core.sv
src/button_press_classifier_top.sv
dv/tb_button_press_classifier_top.sv
